// ===== design/rvalu_pkg.sv =====
package rvalu_pkg;

    // Operation codes.
    localparam logic [4:0] ACT_ADD    = 5'd0;
    localparam logic [4:0] ACT_SUB    = 5'd1;
    localparam logic [4:0] ACT_SLL    = 5'd2;
    localparam logic [4:0] ACT_SLT    = 5'd3;
    localparam logic [4:0] ACT_SLTU   = 5'd4;
    localparam logic [4:0] ACT_XOR    = 5'd5;
    localparam logic [4:0] ACT_SRL    = 5'd6;
    localparam logic [4:0] ACT_SRA    = 5'd7;
    localparam logic [4:0] ACT_OR     = 5'd8;
    localparam logic [4:0] ACT_AND    = 5'd9;
    localparam logic [4:0] ACT_MUL    = 5'd10;
    localparam logic [4:0] ACT_MULH   = 5'd11;
    localparam logic [4:0] ACT_MULHU  = 5'd12;
    localparam logic [4:0] ACT_MULHSU = 5'd13;
    localparam logic [4:0] ACT_DIV    = 5'd14;
    localparam logic [4:0] ACT_DIVU   = 5'd15;
    localparam logic [4:0] ACT_REM    = 5'd16;
    localparam logic [4:0] ACT_REMU   = 5'd17;

    localparam int XLEN = 64;

    // Operands of one beat after word-mode extension.
    typedef struct packed {
        logic [4:0]  act;
        logic        w;
        logic [63:0] a;
        logic [63:0] b;
    } op_t;

    // Divider lane state, carried from stage 1 through the divider.
    typedef struct packed {
        logic [4:0]  act;
        logic        w;
        logic [63:0] early;
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] dsr;
        logic        qneg;
        logic        rneg;
        logic        dz;
        logic [63:0] asx;
    } div_t;

    // Multiplier partial products and the operands for the sign corrections.
    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
        logic [63:0] a;
        logic [63:0] b;
    } mulpp_t;

    // Multiplier sum and correction term.
    typedef struct packed {
        logic [127:0] prod;
        logic [63:0]  corr;
    } mulsum_t;

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

// ===== design/rv64im_integer_alu_top.sv =====
// Fully pipelined RV64IM integer unit. A beat is taken on every cycle that
// start is high; busy is always low. Every operation passes through the same
// stages: an input register, three front stages that hold the 32x32
// partial-product multiplier and its sum and sign correction, a register at
// the head of the divider, the 64-stage restoring divider (one quotient bit
// per stage), and an output register. Results come out in issue order, one
// per cycle at most, each marked by done for one cycle; the receiver must
// take them as they come.
module rv64im_integer_alu_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  action,
    input  logic [63:0] a_operand,
    input  logic [63:0] b_operand,
    input  logic        word_mode,
    output logic        done,
    output logic [63:0] result
);

    localparam int NDIV = rvalu_pkg::XLEN;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Input register with word-mode sign extension.
    logic           p0_valid_reg;
    rvalu_pkg::op_t p0_reg;
    rvalu_pkg::op_t p0_next;

    always_comb
    begin
        p0_next.act = action;
        p0_next.w   = word_mode;
        p0_next.a   = word_mode ? rvalu_pkg::sext32(a_operand) : a_operand;
        p0_next.b   = word_mode ? rvalu_pkg::sext32(b_operand) : b_operand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_valid_reg <= 1'b0;
        else
            p0_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
    end

    // Stage 1: simple ALU ops, divider operand setup, partial products.
    logic              s1_valid_reg;
    rvalu_pkg::div_t   s1_reg;
    rvalu_pkg::div_t   s1_next;
    rvalu_pkg::mulpp_t m1_reg;
    rvalu_pkg::mulpp_t m1_next;

    always_comb
    begin
        logic [5:0]  sh;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic        sgn;
        a   = p0_reg.a;
        b   = p0_reg.b;
        sh  = {b[5] & ~p0_reg.w, b[4:0]};
        case (p0_reg.act)
            rvalu_pkg::ACT_ADD:  r = a + b;
            rvalu_pkg::ACT_SUB:  r = a - b;
            rvalu_pkg::ACT_SLL:  r = a << sh;
            rvalu_pkg::ACT_SLT:  r = {63'd0, $signed(a) < $signed(b)};
            rvalu_pkg::ACT_SLTU: r = {63'd0, a < b};
            rvalu_pkg::ACT_XOR:  r = a ^ b;
            rvalu_pkg::ACT_SRL:  r = (p0_reg.w ? {32'd0, a[31:0]} : a) >> sh;
            rvalu_pkg::ACT_SRA:  r = $unsigned($signed(a) >>> sh);
            rvalu_pkg::ACT_OR:   r = a | b;
            rvalu_pkg::ACT_AND:  r = a & b;
            default:             r = 64'd0;
        endcase
        sgn = (p0_reg.act == rvalu_pkg::ACT_DIV) || (p0_reg.act == rvalu_pkg::ACT_REM);

        s1_next.act   = p0_reg.act;
        s1_next.w     = p0_reg.w;
        s1_next.early = r;
        s1_next.rem   = 64'd0;
        if (sgn)
        begin
            s1_next.dq  = a[63] ? (64'd0 - a) : a;
            s1_next.dsr = b[63] ? (64'd0 - b) : b;
        end
        else
        begin
            s1_next.dq  = p0_reg.w ? {32'd0, a[31:0]} : a;
            s1_next.dsr = p0_reg.w ? {32'd0, b[31:0]} : b;
        end
        s1_next.qneg = sgn & (a[63] ^ b[63]);
        s1_next.rneg = sgn & a[63];
        s1_next.dz   = (b == 64'd0);
        s1_next.asx  = a;

        m1_next.ll = a[31:0]  * b[31:0];
        m1_next.lh = a[31:0]  * b[63:32];
        m1_next.hl = a[63:32] * b[31:0];
        m1_next.hh = a[63:32] * b[63:32];
        m1_next.a  = a;
        m1_next.b  = b;
    end

    // Stage 2: product sum and signed correction.
    logic               s2_valid_reg;
    rvalu_pkg::div_t    s2_reg;
    rvalu_pkg::mulsum_t m2_reg;
    rvalu_pkg::mulsum_t m2_next;

    always_comb
    begin
        logic sub_b;
        logic sub_a;
        sub_b = m1_reg.a[63] && ((s1_reg.act == rvalu_pkg::ACT_MULH) ||
                                 (s1_reg.act == rvalu_pkg::ACT_MULHSU));
        sub_a = m1_reg.b[63] && (s1_reg.act == rvalu_pkg::ACT_MULH);
        m2_next.prod = {m1_reg.hh, 64'd0} + {32'd0, m1_reg.lh, 32'd0}
                     + {32'd0, m1_reg.hl, 32'd0} + {64'd0, m1_reg.ll};
        m2_next.corr = (sub_b ? m1_reg.b : 64'd0) + (sub_a ? m1_reg.a : 64'd0);
    end

    // Stage 3: multiplier result merged into the early result.
    logic            s3_valid_reg;
    rvalu_pkg::div_t s3_reg;
    rvalu_pkg::div_t s3_next;

    always_comb
    begin
        s3_next = s2_reg;
        case (s2_reg.act) inside
            rvalu_pkg::ACT_MUL:    s3_next.early = m2_reg.prod[63:0];
            rvalu_pkg::ACT_MULH,
            rvalu_pkg::ACT_MULHU,
            rvalu_pkg::ACT_MULHSU: s3_next.early = m2_reg.prod[127:64] - m2_reg.corr;
            default:               s3_next.early = s2_reg.early;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= p0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        m1_reg <= m1_next;
        s2_reg <= s1_reg;
        m2_reg <= m2_next;
        s3_reg <= s3_next;
    end

    // Divider pipeline: each stage retires one quotient bit.
    logic            dv_valid_reg [0:NDIV];
    rvalu_pkg::div_t dv_reg       [0:NDIV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= s3_reg;
    end

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        rvalu_pkg::div_t dv_next;

        always_comb
        begin
            logic [64:0] t;
            logic [64:0] d;
            logic        qb;
            dv_next = dv_reg[i];
            t  = {dv_reg[i].rem, dv_reg[i].dq[63]};
            d  = t - {1'b0, dv_reg[i].dsr};
            qb = !d[64];
            dv_next.rem = qb ? d[63:0] : t[63:0];
            dv_next.dq  = {dv_reg[i].dq[62:0], qb};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[i+1] <= 1'b0;
            else
                dv_valid_reg[i+1] <= dv_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            dv_reg[i+1] <= dv_next;
        end
    end

    // Output stage: sign fix-up, special cases, word-mode extension.
    logic        done_reg;
    logic [63:0] result_reg;
    logic [63:0] result_next;

    always_comb
    begin
        rvalu_pkg::div_t f;
        logic [63:0]     r;
        f = dv_reg[NDIV];
        case (f.act) inside
            rvalu_pkg::ACT_DIV,
            rvalu_pkg::ACT_DIVU: r = f.dz ? {64{1'b1}} : (f.qneg ? (64'd0 - f.dq) : f.dq);
            rvalu_pkg::ACT_REM,
            rvalu_pkg::ACT_REMU: r = f.dz ? f.asx : (f.rneg ? (64'd0 - f.rem) : f.rem);
            default:             r = f.early;
        endcase
        result_next = f.w ? rvalu_pkg::sext32(r) : r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid_reg[NDIV];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== test/rv64im_integer_alu_checker.sv =====
`timescale 1ns / 1ps

module rv64im_integer_alu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [4:0]  action,
    input  logic [63:0] a_operand,
    input  logic [63:0] b_operand,
    input  logic        word_mode,
    input  logic        done,
    input  logic [63:0] result,
    output int          fail_count,
    output int          pending
);

    // Results still owed by the unit, oldest first.
    logic [63:0] owed_results[$];

    function automatic logic [63:0] to_word(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Computes the architectural result of one operation.
    function automatic logic [63:0] alu_result(input logic [4:0] op, input logic [63:0] ain,
                                               input logic [63:0] bin, input logic w);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  r;
        logic [5:0]   sh;
        logic [127:0] prod;
        a = w ? to_word(ain) : ain;
        b = w ? to_word(bin) : bin;
        sh = w ? {1'b0, b[4:0]} : b[5:0];
        r = '0;
        case (op)
            rvalu_pkg::ACT_ADD:    r = a + b;
            rvalu_pkg::ACT_SUB:    r = a - b;
            rvalu_pkg::ACT_SLL:    r = a << sh;
            rvalu_pkg::ACT_SLT:    r = {63'd0, $signed(a) < $signed(b)};
            rvalu_pkg::ACT_SLTU:   r = {63'd0, a < b};
            rvalu_pkg::ACT_XOR:    r = a ^ b;
            rvalu_pkg::ACT_SRL:    r = (w ? {32'd0, a[31:0]} : a) >> sh;
            rvalu_pkg::ACT_SRA:    r = $signed(a) >>> sh;
            rvalu_pkg::ACT_OR:     r = a | b;
            rvalu_pkg::ACT_AND:    r = a & b;
            rvalu_pkg::ACT_MUL:    r = a * b;
            rvalu_pkg::ACT_MULH:
            begin
                prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                r = prod[127:64];
            end
            rvalu_pkg::ACT_MULHU:
            begin
                prod = {64'd0, a} * {64'd0, b};
                r = prod[127:64];
            end
            rvalu_pkg::ACT_MULHSU:
            begin
                prod = {{64{a[63]}}, a} * {64'd0, b};
                r = prod[127:64];
            end
            rvalu_pkg::ACT_DIV:
                if (b == 0) r = '1;
                else if (a == 64'h8000000000000000 && b == '1) r = a;
                else r = $signed(a) / $signed(b);
            rvalu_pkg::ACT_DIVU:
                if (b == 0) r = '1;
                else if (w) r = {32'd0, a[31:0]} / {32'd0, b[31:0]};
                else r = a / b;
            rvalu_pkg::ACT_REM:
                if (b == 0) r = a;
                else if (a == 64'h8000000000000000 && b == '1) r = '0;
                else r = $signed(a) % $signed(b);
            rvalu_pkg::ACT_REMU:
                if (b == 0) r = a;
                else if (w) r = {32'd0, a[31:0]} % {32'd0, b[31:0]};
                else r = a % b;
            default:    r = '0;
        endcase
        return w ? to_word(r) : r;
    endfunction

    assign pending = owed_results.size();

    // Predict on each accepted beat and compare each strobed result.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result %h with no beat outstanding", result);
                    fail_count <= fail_count + 1;
                end
                else if (owed_results[0] !== result)
                begin
                    $error("result: expected %h actual %h", owed_results[0], result);
                    fail_count <= fail_count + 1;
                    void'(owed_results.pop_front());
                end
                else
                begin
                    void'(owed_results.pop_front());
                end
            end
            if (start && !busy)
                owed_results.push_back(alu_result(action, a_operand, b_operand, word_mode));
        end
    end

endmodule

// ===== test/rv64im_integer_alu_top_tb.sv =====
`timescale 1ns / 1ps

module rv64im_integer_alu_top_tb;

    localparam int RANDOM_BEATS = 1830;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  action;
    logic [63:0] a_operand;
    logic [63:0] b_operand;
    logic        word_mode;
    logic        done;
    logic [63:0] result;
    int          fail_count;
    int          pending;
    int          idle_cycles;

    rv64im_integer_alu_top dut (.*);

    rv64im_integer_alu_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: cycles without an accepted beat or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rv64im_integer_alu_top_tb NOT OK");
            $finish;
        end
    end

    // Random operand with bias toward interesting values.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000000000000000;
            3: return 64'h7fffffffffffffff;
            4: return {{32{1'b0}}, 32'h80000000};
            5: return {$urandom_range(0, 1) ? 32'hffffffff : 32'd0, $urandom()};
            6: return 64'($urandom_range(0, 70));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Present one beat, hold it until accepted, then, if gaps is set, idle a random gap that may be zero.
    task automatic send_beat(input logic [4:0] op, input logic [63:0] a,
                             input logic [63:0] b, input logic w, input bit gaps);
        int gap;
        start <= 1'b1;
        action <= op;
        a_operand <= a;
        b_operand <= b;
        word_mode <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = gaps && $urandom_range(0, 3) != 0 ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [63:0] edges[6];
        rst_n = 1'b0;
        start = 1'b0;
        action = rvalu_pkg::ACT_ADD;
        a_operand = '0;
        b_operand = '0;
        word_mode = 1'b0;
        edges = '{64'd0, '1, 64'h8000000000000000, 64'h7fffffffffffffff, 64'd1, 64'd63};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation once (word mode for odd codes), division corner cases.
        for (int op = 0; op <= rvalu_pkg::ACT_REMU; op++)
            send_beat(5'(op), edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                      op[0], 1'b0);
        send_beat(rvalu_pkg::ACT_DIV, 64'h8000000000000000, '1, 1'b0, 1'b0);
        send_beat(rvalu_pkg::ACT_REM, 64'h8000000000000000, '1, 1'b0, 1'b0);
        send_beat(rvalu_pkg::ACT_DIV, 64'h80000000, 64'hffffffff, 1'b1, 1'b1);
        send_beat(rvalu_pkg::ACT_REMU, 64'h12345678, 64'd0, 1'b1, 1'b1);
        send_beat(rvalu_pkg::ACT_DIVU, 64'hdeadbeef, 64'd0, 1'b0, 1'b1);
        send_beat(5'd31, '1, '1, 1'b1, 1'b1);

        // Random: mostly defined operations, some undefined codes.
        for (int i = 0; i < RANDOM_BEATS; i++)
            send_beat($urandom_range(0, 19) == 0 ? 5'($urandom_range(18, 31))
                                                 : 5'($urandom_range(0, 17)),
                      pick_operand(), pick_operand(), 1'($urandom_range(0, 1)),
                      i % 200 >= 30);
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("rv64im_integer_alu_top_tb OK");
        else
            $display("rv64im_integer_alu_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rvalu_pkg.sv
design/rv64im_integer_alu_top.sv
test/rv64im_integer_alu_checker.sv
test/rv64im_integer_alu_top_tb.sv
